// File: rtl/core/message_header_deframer_defines.svh
// Assertion macros for the checker file of the deframer.
`ifndef MESSAGE_HEADER_DEFRAMER_DEFINES_SVH
`define MESSAGE_HEADER_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while in reset.
`define MHD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, disabled while in reset.
`define MHD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/mhd_pkg.sv
`timescale 1ns / 1ps
package mhd_pkg;

	localparam int unsigned POS_W = 17;

	localparam logic [7:0] MAGIC_HI = 8'h55;
	localparam logic [7:0] MAGIC_LO = 8'h41;
	localparam logic [7:0] VERSION  = 8'h01;

	localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(12);
	localparam logic [POS_W-1:0] HEADER_LAST  = POS_W'(11);
	localparam logic [POS_W-1:0] POS_MAX      = '1;

	localparam logic [15:0] MAX_BODY = 16'd1024;

	// Header byte offsets
	localparam logic [3:0] HP_MAGIC_HI = 4'd0;
	localparam logic [3:0] HP_MAGIC_LO = 4'd1;
	localparam logic [3:0] HP_VERSION  = 4'd2;
	localparam logic [3:0] HP_TYPE     = 4'd3;
	localparam logic [3:0] HP_SESS0    = 4'd4;
	localparam logic [3:0] HP_SESS1    = 4'd5;
	localparam logic [3:0] HP_SESS2    = 4'd6;
	localparam logic [3:0] HP_SESS3    = 4'd7;
	localparam logic [3:0] HP_SEQ_HI   = 4'd8;
	localparam logic [3:0] HP_SEQ_LO   = 4'd9;
	localparam logic [3:0] HP_LEN_HI   = 4'd10;
	localparam logic [3:0] HP_LEN_LO   = 4'd11;

	typedef enum logic {
		CFG_TYPE_LOWEST  = 1'b0,
		CFG_TYPE_HIGHEST = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [7:0]  body_byte;
		logic        has_byte;
		logic        end_of_message;
		logic        verdict;
		logic [7:0]  message_type;
		logic [31:0] session;
		logic [15:0] seq_number;
		logic [15:0] declared_body_length;
	} result_t;

endpackage

// File: rtl/core/mhd_in_stage.sv
`timescale 1ns / 1ps
module mhd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_final,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1,
	output logic       final_s1
);

	// Hold while the parked byte cannot move on.
	assign in_stall = valid_s1 & ~take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= in_byte;
			final_s1 <= in_final;
		end
	end

endmodule

// File: rtl/core/mhd_parse.sv
`timescale 1ns / 1ps
module mhd_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [7:0]       cfg_data,
	input  logic [7:0]       byte_s1,
	input  logic             final_s1,
	input  logic             take,
	output logic             has_result,
	output mhd_pkg::result_t res
);
	import mhd_pkg::*;

	logic [7:0]       type_lo_q, type_hi_q;
	logic [POS_W-1:0] pos_q, pos_inc, total;
	logic             hbad_q, hbad_n;
	logic [7:0]       type_q, type_n;
	logic [31:0]      sess_q, sess_n;
	logic [15:0]      seq_q, seq_n;
	logic [15:0]      len_q, len_n;
	logic             fwd, bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_lo_q <= 8'd0;
			type_hi_q <= 8'hFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TYPE_LOWEST:  type_lo_q <= cfg_data;
				CFG_TYPE_HIGHEST: type_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		hbad_n = hbad_q;
		type_n = type_q;
		sess_n = sess_q;
		seq_n  = seq_q;
		len_n  = len_q;
		fwd    = 1'b0;
		if (pos_q < HEADER_BYTES) begin
			unique case (pos_q[3:0]) inside
				HP_MAGIC_HI: if (byte_s1 != MAGIC_HI) hbad_n = 1'b1;
				HP_MAGIC_LO: if (byte_s1 != MAGIC_LO) hbad_n = 1'b1;
				HP_VERSION:  if (byte_s1 != VERSION) hbad_n = 1'b1;
				HP_TYPE: begin
					type_n = byte_s1;
					if (byte_s1 < type_lo_q || byte_s1 > type_hi_q) hbad_n = 1'b1;
				end
				HP_SESS0, HP_SESS1, HP_SESS2, HP_SESS3: sess_n = {sess_q[23:0], byte_s1};
				HP_SEQ_HI, HP_SEQ_LO: seq_n = {seq_q[7:0], byte_s1};
				HP_LEN_HI: len_n = {len_q[7:0], byte_s1};
				HP_LEN_LO: begin
					len_n = {len_q[7:0], byte_s1};
					if ({len_q[7:0], byte_s1} > MAX_BODY) hbad_n = 1'b1;
				end
				default: ;
			endcase
		end else begin
			fwd = (pos_q - HEADER_BYTES) < {1'b0, len_q};
		end

		pos_inc = (pos_q == POS_MAX) ? pos_q : pos_q + 1'b1;
		total   = HEADER_BYTES + {1'b0, len_n};
		bad     = hbad_n || (pos_q < HEADER_LAST) || (pos_inc != total);

		has_result                 = fwd | final_s1;
		res.body_byte              = fwd ? byte_s1 : 8'd0;
		res.has_byte               = fwd;
		res.end_of_message         = final_s1;
		res.verdict                = final_s1 & bad;
		res.message_type           = final_s1 ? type_n : 8'd0;
		res.session                = final_s1 ? sess_n : 32'd0;
		res.seq_number             = final_s1 ? seq_n : 16'd0;
		res.declared_body_length   = final_s1 ? len_n : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			hbad_q <= 1'b0;
			type_q <= 8'd0;
			sess_q <= 32'd0;
			seq_q  <= 16'd0;
			len_q  <= 16'd0;
		end else if (take) begin
			if (final_s1) begin
				pos_q  <= '0;
				hbad_q <= 1'b0;
				type_q <= 8'd0;
				sess_q <= 32'd0;
				seq_q  <= 16'd0;
				len_q  <= 16'd0;
			end else begin
				pos_q  <= pos_inc;
				hbad_q <= hbad_n;
				type_q <= type_n;
				sess_q <= sess_n;
				seq_q  <= seq_n;
				len_q  <= len_n;
			end
		end
	end

endmodule

// File: rtl/core/mhd_out_stage.sv
`timescale 1ns / 1ps
module mhd_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mhd_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             ready,
	output mhd_pkg::result_t res_q
);

	assign ready = ~out_valid | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (load) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

// File: rtl/core/message_header_deframer.sv
`timescale 1ns / 1ps
// Message header deframer.
// Input channel: one raw message byte per transfer (in_byte), with in_final
// set on the last byte of a message. The 12-byte header is checked and its
// fields captured; body bytes up to the declared length come out as they
// arrive, one result per forwarded byte. The final byte yields a result with
// end_of_message set, the verdict (1 = bad) and the captured header fields;
// a body byte may ride on that same result.
// Bytes that produce no result (header bytes, surplus body bytes) are
// absorbed without touching the output channel.
// A result passes through the input register, then the result register.
// Throughput: one byte per cycle unless the receiver stalls, set by the
// single input register stage feeding the result register; the block keeps
// taking bytes while a result waits on a stalled receiver, until both
// registers are full.
// Reset clears the message state and sets the type window to 0..255.
// When the receiver stalls, the result register holds its payload and the
// input side stalls once the input register holds a byte that needs it.
// Write the type window through cfg_we/cfg_index/cfg_data only while idle.
module message_header_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  in_byte,
	input  logic        in_final,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  body_byte,
	output logic        has_byte,
	output logic        end_of_message,
	output logic        verdict,
	output logic [7:0]  message_type,
	output logic [31:0] session,
	output logic [15:0] seq_number,
	output logic [15:0] declared_body_length
);
	import mhd_pkg::*;

	logic       valid_s1, final_s1, take, has_result, out_ready;
	logic [7:0] byte_s1;
	result_t    res, res_q;

	// Advance the parked byte when it makes no result or the output has room.
	assign take = valid_s1 & (~has_result | out_ready);

	mhd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.in_final (in_final),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.final_s1 (final_s1)
	);

	mhd_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.byte_s1    (byte_s1),
		.final_s1   (final_s1),
		.take       (take),
		.has_result (has_result),
		.res        (res)
	);

	mhd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take & has_result),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.ready     (out_ready),
		.res_q     (res_q)
	);

	// Drive the result fields from the result register.
	assign body_byte            = res_q.body_byte;
	assign has_byte             = res_q.has_byte;
	assign end_of_message       = res_q.end_of_message;
	assign verdict              = res_q.verdict;
	assign message_type         = res_q.message_type;
	assign session              = res_q.session;
	assign seq_number           = res_q.seq_number;
	assign declared_body_length = res_q.declared_body_length;

endmodule

// File: rtl/core/mhd_checker.sv
`timescale 1ns / 1ps
`include "message_header_deframer_defines.svh"
module mhd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  body_byte,
	input logic        has_byte,
	input logic        end_of_message,
	input logic        verdict,
	input logic [7:0]  message_type,
	input logic [31:0] session,
	input logic [15:0] seq_number,
	input logic [15:0] declared_body_length
);
	import mhd_pkg::*;

	`MHD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(body_byte) && $stable(has_byte) && $stable(end_of_message) && $stable(verdict), "stalled result changed")
	`MHD_ASSERT_NOW(a_not_empty, out_valid, has_byte || end_of_message, "result carries neither byte nor end")
	`MHD_ASSERT_NOW(a_mid_zero, out_valid && !end_of_message, !verdict && message_type == 8'd0 && session == 32'd0 && seq_number == 16'd0 && declared_body_length == 16'd0, "header fields set before end")
	`MHD_ASSERT_NOW(a_byte_zero, out_valid && !has_byte, body_byte == 8'd0, "body byte set without has_byte")
	`MHD_ASSERT_NOW(a_long_bad, out_valid && end_of_message && declared_body_length > MAX_BODY, verdict, "oversize body not flagged")

endmodule

bind message_header_deframer mhd_checker u_mhd_checker (.*);
